// ----- design/mma_pkg.sv -----
package mma_pkg;

  localparam int DEF_MAX_DIM    = 16;
  localparam int DEF_ELEM_WIDTH = 16;
  localparam int C_WIDTH        = 48;
  localparam int C_FRAC         = 30;
  localparam int IDX_MAX_W      = 6;   // enough for the largest array size
  localparam int CFG_W          = 5;

  typedef enum logic [2:0] {
    FN_LOAD_A = 3'd0,
    FN_LOAD_B = 3'd1,
    FN_LOAD_C = 3'd2,
    FN_ACC    = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  // one step of the accumulation as it travels down the chain
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last;
    logic [IDX_MAX_W-1:0] j;
    logic [IDX_MAX_W-1:0] k;
  } tok_t;

  // host side writes into one cell
  typedef struct packed {
    logic                 we_a;
    logic                 we_c;
    logic [IDX_MAX_W-1:0] addr;
  } host_t;

endpackage

// ----- design/mma_ram.sv -----
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mma_cell.sv -----
module mma_cell import mma_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         row_en,
  input  tok_t                         tok_in,
  input  logic signed [ELEM_WIDTH-1:0] bv_in,
  input  host_t                        host,
  input  logic [ELEM_WIDTH-1:0]        host_wa,
  input  logic [C_WIDTH-1:0]           host_wc,
  output tok_t                         tok_out,
  output logic signed [ELEM_WIDTH-1:0] bv_out,
  output logic [C_WIDTH-1:0]           c_rdata
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int PW = 2 * ELEM_WIDTH;
  localparam int PF = 2 * ELEM_WIDTH - 2;
  localparam int SHR = (PF >= C_FRAC) ? PF - C_FRAC : 0;
  localparam int SHL = (PF >= C_FRAC) ? 0 : C_FRAC - PF;
  localparam logic signed [C_WIDTH-1:0] C_MAX = {1'b0, {(C_WIDTH-1){1'b1}}};
  localparam logic signed [C_WIDTH-1:0] C_MIN = {1'b1, {(C_WIDTH-1){1'b0}}};

  tok_t                         s1, s2, s3;
  logic signed [ELEM_WIDTH-1:0] bv1;
  logic signed [PW-1:0]         prod;
  logic signed [C_WIDTH-1:0]    cbase;
  logic signed [C_WIDTH-1:0]    acc;
  logic [ELEM_WIDTH-1:0]        a_rd;
  logic [C_WIDTH-1:0]           c_rd;

  logic signed [63:0]           pext;
  logic signed [63:0]           palign;
  logic signed [C_WIDTH-1:0]    base;
  logic signed [C_WIDTH:0]      sum;
  logic signed [C_WIDTH-1:0]    acc_next;

  logic                         c_we;
  logic [IW-1:0]                c_waddr;
  logic [C_WIDTH-1:0]           c_wdata;
  logic [IW-1:0]                c_raddr;

  mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM)) u_a_ram (
    .clk   (clk),
    .we    (host.we_a),
    .waddr (host.addr[IW-1:0]),
    .wdata (host_wa),
    .raddr (tok_in.k[IW-1:0]),
    .rdata (a_rd)
  );

  always_comb begin
    c_we    = host.we_c || (s3.valid && s3.last && row_en);
    c_waddr = host.we_c ? host.addr[IW-1:0] : s3.j[IW-1:0];
    c_wdata = host.we_c ? host_wc : acc;
    c_raddr = tok_in.valid ? tok_in.j[IW-1:0] : host.addr[IW-1:0];
  end

  mma_ram #(.WIDTH(C_WIDTH), .DEPTH(MAX_DIM)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  // product is moved to the 30 fraction bits of C, floor on right shift
  always_comb begin
    pext     = 64'(prod);
    palign   = (pext <<< SHL) >>> SHR;
    base     = s2.first ? cbase : acc;
    sum      = {base[C_WIDTH-1], base} + {palign[C_WIDTH-1], palign[C_WIDTH-1:0]};
    if (sum[C_WIDTH] != sum[C_WIDTH-1]) begin
      acc_next = sum[C_WIDTH] ? C_MIN : C_MAX;
    end else begin
      acc_next = sum[C_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1      <= '0;
      s2      <= '0;
      s3      <= '0;
      tok_out <= '0;
    end else begin
      s1      <= tok_in;
      s2      <= s1;
      s3      <= s2;
      tok_out <= tok_in;
    end
    bv1    <= bv_in;
    bv_out <= bv_in;
    prod   <= bv1 * $signed(a_rd);
    cbase  <= c_rd;
    if (s2.valid) begin
      acc <= acc_next;
    end
  end

  assign c_rdata = c_rd;

endmodule

// ----- design/matrix_multiply_accumulate.sv -----
// Channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// command  | start, busy            | func, row, col, value
// result   | res_valid (strobe)     | row_res, col_res, result
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// Loads write their memory at the transfer; a read raises its strobe through the rd_pend and res_valid registers.
// Accumulate holds busy through the run and the drain: the B memory feeds one
// (column, inner) step per cycle into the row of cells, one cell per row of C.
// With a zero dimension accumulate does nothing and busy stays low.
// Config writes wait while busy or start is high.
// Reset is synchronous; memories are not cleared. Results cannot be stalled.
module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                func,
  input  logic [3:0]                row,
  input  logic [3:0]                col,
  input  logic signed [C_WIDTH-1:0] value,
  output logic                      res_valid,
  output logic [3:0]                row_res,
  output logic [3:0]                col_res,
  output logic signed [C_WIDTH-1:0] result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int WW = (DW > CFG_W) ? DW : CFG_W;
  localparam int DRAIN_LEN = MAX_DIM + 5;
  localparam int DCW = $clog2(DRAIN_LEN + 1);
  localparam logic signed [C_WIDTH-1:0] E_MAX =
    (C_WIDTH'(1) <<< (ELEM_WIDTH - 1)) - C_WIDTH'(1);
  localparam logic signed [C_WIDTH-1:0] E_MIN = -E_MAX - C_WIDTH'(1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t               state;
  logic [CFG_W-1:0]     rows_in_use, inner_in_use, cols_in_use;
  logic [IW-1:0]        j, k;
  logic [DCW-1:0]       drain_cnt;
  tok_t                 tok_r;

  logic                 accept;
  logic [IW+3:0]        row_w, col_w;
  logic [IW-1:0]        row_idx, col_idx;
  logic                 in_range;
  logic [WW-1:0]        n_eff, p_eff, m_eff;
  logic                 last_k, last_j;
  logic [ELEM_WIDTH-1:0] sat_val;

  logic                 b_we;
  logic [2*IW-1:0]      b_waddr, b_raddr;
  logic [ELEM_WIDTH-1:0] b_rd;

  logic                 rd_pend, pend_inside;
  logic [3:0]           pend_row, pend_col;
  logic [IW-1:0]        pend_ridx;

  tok_t                         chain_tok [MAX_DIM+1];
  logic signed [ELEM_WIDTH-1:0] chain_bv  [MAX_DIM+1];
  logic [C_WIDTH-1:0]           c_rd_arr  [MAX_DIM];

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;

  always_comb begin
    row_w    = (IW+4)'(row);
    col_w    = (IW+4)'(col);
    row_idx  = row_w[IW-1:0];
    col_idx  = col_w[IW-1:0];
    in_range = (row_w < (IW+4)'(MAX_DIM)) && (col_w < (IW+4)'(MAX_DIM));
    n_eff   = (WW'(rows_in_use)  > WW'(MAX_DIM)) ? WW'(MAX_DIM) : WW'(rows_in_use);
    p_eff   = (WW'(inner_in_use) > WW'(MAX_DIM)) ? WW'(MAX_DIM) : WW'(inner_in_use);
    m_eff   = (WW'(cols_in_use)  > WW'(MAX_DIM)) ? WW'(MAX_DIM) : WW'(cols_in_use);
    last_k  = (WW'(k) + WW'(1)) == p_eff;
    last_j  = (WW'(j) + WW'(1)) == m_eff;
    if (value > E_MAX) begin
      sat_val = E_MAX[ELEM_WIDTH-1:0];
    end else if (value < E_MIN) begin
      sat_val = E_MIN[ELEM_WIDTH-1:0];
    end else begin
      sat_val = value[ELEM_WIDTH-1:0];
    end
    b_we    = accept && (func == FN_LOAD_B) && in_range;
    b_waddr = {col_idx, row_idx};
    b_raddr = {j, k};
  end

  mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(1 << (2 * IW))) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (sat_val),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  assign chain_tok[0] = tok_r;
  assign chain_bv[0]  = $signed(b_rd);

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    host_t host_i;
    logic  row_en_i;

    always_comb begin
      host_i.we_a = accept && (func == FN_LOAD_A) && in_range && (row_idx == IW'(i));
      host_i.we_c = accept && (func == FN_LOAD_C) && in_range && (row_idx == IW'(i));
      host_i.addr = IDX_MAX_W'(col_idx);
      row_en_i    = WW'(i) < n_eff;
    end

    mma_cell #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .row_en  (row_en_i),
      .tok_in  (chain_tok[i]),
      .bv_in   (chain_bv[i]),
      .host    (host_i),
      .host_wa (sat_val),
      .host_wc (value),
      .tok_out (chain_tok[i+1]),
      .bv_out  (chain_bv[i+1]),
      .c_rdata (c_rd_arr[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rows_in_use  <= CFG_W'(16);
      inner_in_use <= CFG_W'(16);
      cols_in_use  <= CFG_W'(16);
      j            <= '0;
      k            <= '0;
      drain_cnt    <= '0;
      tok_r        <= '0;
      rd_pend      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS:  rows_in_use  <= cfg_data;
          REG_INNER: inner_in_use <= cfg_data;
          REG_COLS:  cols_in_use  <= cfg_data;
          default:   ;
        endcase
      end
      rd_pend   <= accept && (func == FN_READ);
      res_valid <= rd_pend;
      unique case (state)
        ST_IDLE: begin
          tok_r <= '0;
          if (accept && (func == FN_ACC) && (n_eff != '0) && (p_eff != '0) &&
              (m_eff != '0)) begin
            state <= ST_RUN;
            j     <= '0;
            k     <= '0;
          end
        end
        ST_RUN: begin
          tok_r <= '{valid: 1'b1, first: (k == '0), last: last_k,
                     j: IDX_MAX_W'(j), k: IDX_MAX_W'(k)};
          if (last_k) begin
            k <= '0;
            if (last_j) begin
              state     <= ST_DRAIN;
              drain_cnt <= '0;
            end else begin
              j <= j + IW'(1);
            end
          end else begin
            k <= k + IW'(1);
          end
        end
        ST_DRAIN: begin
          tok_r     <= '0;
          drain_cnt <= drain_cnt + DCW'(1);
          if (drain_cnt == DCW'(DRAIN_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
          tok_r <= '0;
        end
      endcase
    end
    if (accept) begin
      pend_row    <= row;
      pend_col    <= col;
      pend_inside <= in_range;
      pend_ridx   <= in_range ? row_idx : '0;
    end
    row_res <= pend_row;
    col_res <= pend_col;
    result  <= pend_inside ? $signed(c_rd_arr[pend_ridx]) : '0;
  end

`ifndef SYNTHESIS
  a_res_from_read: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(rd_pend))
    else $error("result strobe without a read");

  a_read_idle: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_IDLE))
    else $error("read pending while accumulating");

  a_busy_by_acc: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (func == FN_ACC)))
    else $error("busy raised without accumulate command");

  a_no_tok_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> !tok_r.valid)
    else $error("step issued outside run");
`endif

endmodule
